@@ rtl/pe_base_relocation_parser_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the base relocation parser
// Immediate-implication and next-cycle-implication checks with async reset.
// ----------------------------------------------------------------------------
`ifndef PE_BASE_RELOCATION_PARSER_UNIT_ASSERT_SVH
`define PE_BASE_RELOCATION_PARSER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PBRP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PBRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/pbrp_pkg.sv @@
// ----------------------------------------------------------------------------
// pbrp_pkg
// Shared types and codes of the base relocation parser.
// ----------------------------------------------------------------------------
package pbrp_pkg;

	localparam int HW_W    = 16;
	localparam int DELTA_W = 64;
	localparam int ADDR_W  = 32;
	localparam int OFF_W   = 33;
	localparam int CNT_W   = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [1:0] KIND_FIXUP = 2'd0;
	localparam logic [1:0] KIND_DONE  = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [1:0] FW_16 = 2'd0;
	localparam logic [1:0] FW_32 = 2'd1;
	localparam logic [1:0] FW_64 = 2'd2;

	localparam logic [2:0] ERR_ZERO_SIZE      = 3'd0;
	localparam logic [2:0] ERR_OVER_DIRECTORY = 3'd1;
	localparam logic [2:0] ERR_PAST_IMAGE     = 3'd2;
	localparam logic [2:0] ERR_BAD_PAGE       = 3'd3;
	localparam logic [2:0] ERR_UNKNOWN_TYPE   = 3'd4;
	localparam logic [2:0] ERR_TABLE_OVERFLOW = 3'd5;
	localparam logic [2:0] ERR_MALFORMED_SIZE = 3'd6;

	localparam logic [3:0] ETYPE_ABS     = 4'd0;
	localparam logic [3:0] ETYPE_HIGH    = 4'd1;
	localparam logic [3:0] ETYPE_LOW     = 4'd2;
	localparam logic [3:0] ETYPE_HIGHLOW = 4'd3;
	localparam logic [3:0] ETYPE_DIR64   = 4'd10;

	localparam logic [CFG_IDX_W-1:0] CFG_LOAD_DELTA     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DIRECTORY_SIZE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TABLE_OFFSET   = 2'd3;

	typedef struct packed {
		logic [DELTA_W-1:0] load_delta;
		logic [ADDR_W-1:0]  image_size;
		logic [ADDR_W-1:0]  directory_size;
		logic [ADDR_W-1:0]  table_offset;
	} cfg_t;

endpackage

@@ rtl/pbrp_if.sv @@
// ----------------------------------------------------------------------------
// pbrp_in_if / pbrp_out_if
// Valid/ready channels for table halfwords and parser results.
// ----------------------------------------------------------------------------
interface pbrp_in_if;
	logic        valid;
	logic        ready;
	logic        table_start;
	logic [15:0] halfword;

	modport source (output valid, output table_start, output halfword, input ready);
	modport sink (input valid, input table_start, input halfword, output ready);
endinterface

interface pbrp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [32:0] fixup_offset;
	logic [1:0]  fixup_width;
	logic [63:0] addend;
	logic [2:0]  error_code;
	logic [15:0] block_index;

	modport source (output valid, output result_kind, output fixup_offset,
		output fixup_width, output addend, output error_code, output block_index,
		input ready);
	modport sink (input valid, input result_kind, input fixup_offset,
		input fixup_width, input addend, input error_code, input block_index,
		output ready);
endinterface

@@ rtl/pe_base_relocation_parser_unit.sv @@
// ----------------------------------------------------------------------------
// pe_base_relocation_parser_unit: base relocation table parser, top level
// Path: a taken item is held in the input register, and a result it causes in the result register.
// Throughput: one halfword item per cycle while the result side keeps taking.
// Reset: all registers zero, parser idle until an item that starts a table.
// ----------------------------------------------------------------------------
module pe_base_relocation_parser_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pbrp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pbrp_pkg::DELTA_W-1:0]   cfg_wdata,
	pbrp_in_if.sink                        item_in,
	pbrp_out_if.source                     result_out
);

	pbrp_pkg::cfg_t cfg;

	pbrp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	pbrp_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_in    (item_in),
		.result_out (result_out)
	);

endmodule

@@ rtl/pbrp_cfg.sv @@
// ----------------------------------------------------------------------------
// pbrp_cfg
// Configuration register file written through a plain write port.
// ----------------------------------------------------------------------------
module pbrp_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pbrp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pbrp_pkg::DELTA_W-1:0]   cfg_wdata,
	output pbrp_pkg::cfg_t                 cfg
);

	pbrp_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				pbrp_pkg::CFG_LOAD_DELTA: begin
					cfg_q.load_delta <= cfg_wdata;
				end
				pbrp_pkg::CFG_IMAGE_SIZE: begin
					cfg_q.image_size <= cfg_wdata[pbrp_pkg::ADDR_W-1:0];
				end
				pbrp_pkg::CFG_DIRECTORY_SIZE: begin
					cfg_q.directory_size <= cfg_wdata[pbrp_pkg::ADDR_W-1:0];
				end
				pbrp_pkg::CFG_TABLE_OFFSET: begin
					cfg_q.table_offset <= cfg_wdata[pbrp_pkg::ADDR_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/pbrp_core.sv @@
// ----------------------------------------------------------------------------
// pbrp_core
// Input register, block parser state machine and result register.
// ----------------------------------------------------------------------------
`include "pe_base_relocation_parser_unit_assert.svh"

module pbrp_core (
	input  logic           clk,
	input  logic           arst_n,
	input  pbrp_pkg::cfg_t cfg,
	pbrp_in_if.sink        item_in,
	pbrp_out_if.source     result_out
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HDR0,
		PH_HDR1,
		PH_HDR2,
		PH_HDR3,
		PH_ENTRY,
		PH_PEND
	} phase_t;

	logic                        valid_s1;
	logic                        start_s1;
	logic [pbrp_pkg::HW_W-1:0]   hw_s1;

	phase_t                      ph_q, ph_d;
	logic [pbrp_pkg::ADDR_W-1:0] page_q, page_d;
	logic [15:0]                 size_lo_q, size_lo_d;
	logic [pbrp_pkg::ADDR_W-1:0] left_q, left_d;
	logic [pbrp_pkg::OFF_W-1:0]  pos_q, pos_d;
	logic [pbrp_pkg::OFF_W-1:0]  bstart_q, bstart_d;
	logic [pbrp_pkg::CNT_W-1:0]  cnt_q, cnt_d;

	logic                         out_valid_q;
	logic [1:0]                   kind_q, kind_d;
	logic [pbrp_pkg::OFF_W-1:0]   off_q, off_d;
	logic [1:0]                   width_q, width_d;
	logic [pbrp_pkg::DELTA_W-1:0] addend_q, addend_d;
	logic [2:0]                   err_q, err_d;
	logic [pbrp_pkg::CNT_W-1:0]   index_q, index_d;
	logic                         emit_d;

	logic                         advance;
	logic                         proc;
	logic [pbrp_pkg::OFF_W-1:0]   table_last;
	logic [pbrp_pkg::OFF_W-1:0]   table_end;
	logic                         base_ok;
	logic                         last_ok;
	logic                         start_stop;
	logic                         start_err;
	logic [pbrp_pkg::CNT_W-1:0]   cnt_inc;

	assign advance       = !out_valid_q || result_out.ready;
	assign proc          = valid_s1 && advance;
	assign item_in.ready = !valid_s1 || advance;

	assign table_last = {1'b0, cfg.table_offset} + {1'b0, cfg.directory_size} - 33'd1;
	assign table_end  = {1'b0, cfg.table_offset} + {1'b0, cfg.directory_size};
	assign base_ok    = cfg.table_offset < cfg.image_size;
	assign last_ok    = table_last < {1'b0, cfg.image_size};
	assign start_err  = (cfg.directory_size != '0) && (base_ok != last_ok);
	assign start_stop = (cfg.directory_size == '0) || !base_ok || !last_ok ||
		(cfg.load_delta == '0) || (cfg.directory_size == 32'd1);
	assign cnt_inc    = (cnt_q == '1) ? cnt_q : cnt_q + 16'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			start_s1 <= 1'b0;
			hw_s1    <= '0;
		end else if (item_in.ready) begin
			valid_s1 <= item_in.valid;
			if (item_in.valid) begin
				start_s1 <= item_in.table_start;
				hw_s1    <= item_in.halfword;
			end
		end
	end

	always_comb begin
		phase_t                      eff_ph;
		logic [pbrp_pkg::OFF_W-1:0]  eff_pos;
		logic [pbrp_pkg::OFF_W-1:0]  pos_adv;
		logic [pbrp_pkg::ADDR_W-1:0] size;
		logic                        blk_end;
		logic                        consumed;

		ph_d      = ph_q;
		page_d    = page_q;
		size_lo_d = size_lo_q;
		left_d    = left_q;
		pos_d     = pos_q;
		bstart_d  = bstart_q;
		cnt_d     = cnt_q;
		emit_d    = 1'b0;
		kind_d    = pbrp_pkg::KIND_FIXUP;
		off_d     = '0;
		width_d   = pbrp_pkg::FW_16;
		addend_d  = '0;
		err_d     = pbrp_pkg::ERR_ZERO_SIZE;
		index_d   = cnt_q;
		eff_ph    = ph_q;
		eff_pos   = pos_q;
		blk_end   = 1'b0;
		size      = {hw_s1, size_lo_q};

		if (start_s1) begin
			cnt_d     = '0;
			index_d   = '0;
			page_d    = '0;
			size_lo_d = '0;
			left_d    = '0;
			eff_ph    = PH_HDR0;
			eff_pos   = {1'b0, cfg.table_offset};
			pos_d     = eff_pos;
		end
		pos_adv  = eff_pos + 33'd2;
		consumed = (cfg.directory_size == '0) ||
			({1'b0, eff_pos} + 34'd3 >= {1'b0, table_end});

		if (start_s1 && start_stop) begin
			ph_d   = PH_IDLE;
			emit_d = 1'b1;
			kind_d = start_err ? pbrp_pkg::KIND_ERROR : pbrp_pkg::KIND_DONE;
			err_d  = start_err ? pbrp_pkg::ERR_TABLE_OVERFLOW : pbrp_pkg::ERR_ZERO_SIZE;
		end else begin
			case (eff_ph)
				PH_HDR0: begin
					page_d   = {16'h0000, hw_s1};
					bstart_d = eff_pos;
					pos_d    = pos_adv;
					ph_d     = PH_HDR1;
				end
				PH_HDR1: begin
					page_d = {hw_s1, page_q[15:0]};
					pos_d  = pos_adv;
					ph_d   = PH_HDR2;
				end
				PH_HDR2: begin
					size_lo_d = hw_s1;
					pos_d     = pos_adv;
					ph_d      = PH_HDR3;
				end
				PH_HDR3: begin
					pos_d = pos_adv;
					if (size == '0) begin
						emit_d = 1'b1;
						err_d  = pbrp_pkg::ERR_ZERO_SIZE;
					end else if (size > cfg.directory_size) begin
						emit_d = 1'b1;
						err_d  = pbrp_pkg::ERR_OVER_DIRECTORY;
					end else if ((size < 32'd8) || size[0]) begin
						emit_d = 1'b1;
						err_d  = pbrp_pkg::ERR_MALFORMED_SIZE;
					end else if ({1'b0, bstart_q} + {2'b00, size} >
						{2'b00, cfg.image_size}) begin
						emit_d = 1'b1;
						err_d  = pbrp_pkg::ERR_PAST_IMAGE;
					end else if (page_q >= cfg.image_size) begin
						emit_d = 1'b1;
						err_d  = pbrp_pkg::ERR_BAD_PAGE;
					end else begin
						left_d = size - 32'd8;
						if (size == 32'd8) begin
							blk_end = 1'b1;
						end else begin
							ph_d = PH_ENTRY;
						end
					end
					if (emit_d) begin
						kind_d = pbrp_pkg::KIND_ERROR;
						ph_d   = PH_IDLE;
					end
				end
				PH_ENTRY: begin
					pos_d  = pos_adv;
					left_d = (left_q >= 32'd2) ? left_q - 32'd2 : '0;
					off_d  = {1'b0, page_q} + {21'd0, hw_s1[11:0]};
					case (hw_s1[15:12])
						pbrp_pkg::ETYPE_ABS: begin
							off_d = '0;
						end
						pbrp_pkg::ETYPE_HIGH: begin
							emit_d   = 1'b1;
							width_d  = pbrp_pkg::FW_16;
							addend_d = {48'd0, cfg.load_delta[31:16]};
						end
						pbrp_pkg::ETYPE_LOW: begin
							emit_d   = 1'b1;
							width_d  = pbrp_pkg::FW_16;
							addend_d = {48'd0, cfg.load_delta[15:0]};
						end
						pbrp_pkg::ETYPE_HIGHLOW: begin
							emit_d   = 1'b1;
							width_d  = pbrp_pkg::FW_32;
							addend_d = {32'd0, cfg.load_delta[31:0]};
						end
						pbrp_pkg::ETYPE_DIR64: begin
							emit_d   = 1'b1;
							width_d  = pbrp_pkg::FW_64;
							addend_d = cfg.load_delta;
						end
						default: begin
							emit_d = 1'b1;
							kind_d = pbrp_pkg::KIND_ERROR;
							err_d  = pbrp_pkg::ERR_UNKNOWN_TYPE;
							off_d  = '0;
							ph_d   = PH_IDLE;
						end
					endcase
					if ((kind_d != pbrp_pkg::KIND_ERROR) && (left_d == '0)) begin
						blk_end = 1'b1;
					end
				end
				PH_PEND: begin
					emit_d = 1'b1;
					kind_d = pbrp_pkg::KIND_DONE;
					ph_d   = PH_IDLE;
				end
				default: begin
					ph_d = PH_IDLE;
				end
			endcase
		end

		if (blk_end) begin
			cnt_d = cnt_inc;
			if (!consumed) begin
				ph_d = PH_HDR0;
			end else if (emit_d) begin
				ph_d = PH_PEND;
			end else begin
				emit_d  = 1'b1;
				kind_d  = pbrp_pkg::KIND_DONE;
				index_d = cnt_inc;
				ph_d    = PH_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q        <= PH_IDLE;
			page_q      <= '0;
			size_lo_q   <= '0;
			left_q      <= '0;
			pos_q       <= '0;
			bstart_q    <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			kind_q      <= pbrp_pkg::KIND_FIXUP;
			off_q       <= '0;
			width_q     <= pbrp_pkg::FW_16;
			addend_q    <= '0;
			err_q       <= pbrp_pkg::ERR_ZERO_SIZE;
			index_q     <= '0;
		end else begin
			if (proc) begin
				ph_q      <= ph_d;
				page_q    <= page_d;
				size_lo_q <= size_lo_d;
				left_q    <= left_d;
				pos_q     <= pos_d;
				bstart_q  <= bstart_d;
				cnt_q     <= cnt_d;
			end
			if (advance) begin
				out_valid_q <= proc && emit_d;
				if (proc && emit_d) begin
					kind_q   <= kind_d;
					off_q    <= off_d;
					width_q  <= width_d;
					addend_q <= addend_d;
					err_q    <= err_d;
					index_q  <= index_d;
				end
			end
		end
	end

	assign result_out.valid        = out_valid_q;
	assign result_out.result_kind  = kind_q;
	assign result_out.fixup_offset = off_q;
	assign result_out.fixup_width  = width_q;
	assign result_out.addend       = addend_q;
	assign result_out.error_code   = err_q;
	assign result_out.block_index  = index_q;

	`PBRP_ASSERT_NOW(a_err_code_only_on_error, clk, arst_n,
		out_valid_q && (kind_q != pbrp_pkg::KIND_ERROR),
		err_q == pbrp_pkg::ERR_ZERO_SIZE, "error code set on a non-error item")
	`PBRP_ASSERT_NOW(a_end_payload_zero, clk, arst_n,
		out_valid_q && (kind_q != pbrp_pkg::KIND_FIXUP),
		(off_q == '0) && (width_q == pbrp_pkg::FW_16) && (addend_q == '0),
		"done or error item carries fixup payload")
	`PBRP_ASSERT_NEXT(a_end_goes_idle, clk, arst_n,
		proc && emit_d && (kind_d != pbrp_pkg::KIND_FIXUP),
		ph_q == PH_IDLE, "parser not idle after ending a run")
	`PBRP_ASSERT_NOW(a_narrow_addend, clk, arst_n,
		out_valid_q && (kind_q == pbrp_pkg::KIND_FIXUP) && (width_q == pbrp_pkg::FW_16),
		addend_q[63:16] == '0, "sixteen-bit fixup with wide addend")

endmodule

@@ bench/relocation_result_checker.sv @@
// ----------------------------------------------------------------------------
// relocation_result_checker
// Watches the configuration port and both channels of the relocation parser.
// Every accepted halfword item updates a private copy of the parser state.
// The fixup, done and error results that this copy predicts are queued, and
// each result item taken from the block is compared with the oldest of them.
// ----------------------------------------------------------------------------
module relocation_result_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pbrp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pbrp_pkg::DELTA_W-1:0]   cfg_wdata,
	pbrp_in_if                             item_mon,
	pbrp_out_if                            result_mon,
	output int                             mismatches,
	output int                             outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import pbrp_pkg::*;

	localparam logic [2:0] NO_ERROR = 3'd0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAGE_LO,
		ST_PAGE_HI,
		ST_SIZE_LO,
		ST_SIZE_HI,
		ST_ENTRY,
		ST_DONE_PENDING
	} parse_state_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [32:0] offset;
		logic [1:0]  width;
		logic [63:0] addend;
		logic [2:0]  err;
		logic [15:0] index;
	} relo_result_t;

	logic [63:0]  cfg_delta;
	logic [31:0]  cfg_image_size;
	logic [31:0]  cfg_dir_size;
	logic [31:0]  cfg_offset;

	parse_state_t state;
	logic [31:0]  page_addr;
	logic [31:0]  blk_size;
	logic [31:0]  bytes_left;
	logic [63:0]  tbl_pos;
	logic [15:0]  blk_count;
	logic         finished;

	relo_result_t awaited_results[$];

	function automatic relo_result_t close_run(input logic [1:0] kind, input logic [2:0] err);
		relo_result_t r;
		r = '0;
		r.kind = kind;
		r.err = err;
		r.index = blk_count;
		state = ST_IDLE;
		finished = 1'b1;
		return r;
	endfunction

	function automatic bit close_block(input bit have, inout relo_result_t res);
		if (blk_count != 16'hFFFF)
			blk_count++;
		if (cfg_dir_size == 0 ||
				tbl_pos + 64'd1 >= {32'd0, cfg_offset} + {32'd0, cfg_dir_size}) begin
			if (have) begin
				state = ST_DONE_PENDING;
				return 1'b1;
			end
			res = close_run(KIND_DONE, NO_ERROR);
			return 1'b1;
		end
		state = ST_PAGE_LO;
		return have;
	endfunction

	function automatic bit parse_halfword(input logic start, input logic [15:0] hw,
			output relo_result_t res);
		logic [63:0] table_last;
		logic [63:0] blk_start;
		logic [3:0]  etype;
		bit          have;
		res = '0;
		if (start) begin
			blk_count = '0;
			tbl_pos = {32'd0, cfg_offset};
			page_addr = '0;
			blk_size = '0;
			bytes_left = '0;
			finished = 1'b0;
			table_last = {32'd0, cfg_offset} + {32'd0, cfg_dir_size} - 64'd1;
			if (cfg_dir_size == 0) begin
				res = close_run(KIND_DONE, NO_ERROR);
				return 1'b1;
			end
			if (cfg_offset >= cfg_image_size && table_last >= {32'd0, cfg_image_size}) begin
				res = close_run(KIND_DONE, NO_ERROR);
				return 1'b1;
			end
			if (cfg_offset >= cfg_image_size || table_last >= {32'd0, cfg_image_size}) begin
				res = close_run(KIND_ERROR, ERR_TABLE_OVERFLOW);
				return 1'b1;
			end
			if (cfg_delta == 0 || cfg_dir_size == 1) begin
				res = close_run(KIND_DONE, NO_ERROR);
				return 1'b1;
			end
			state = ST_PAGE_LO;
		end else if (finished) begin
			return 1'b0;
		end

		case (state)
			ST_PAGE_LO: begin
				page_addr = {16'd0, hw};
				tbl_pos += 64'd2;
				state = ST_PAGE_HI;
				return 1'b0;
			end
			ST_PAGE_HI: begin
				page_addr[31:16] = hw;
				tbl_pos += 64'd2;
				state = ST_SIZE_LO;
				return 1'b0;
			end
			ST_SIZE_LO: begin
				blk_size = {16'd0, hw};
				tbl_pos += 64'd2;
				state = ST_SIZE_HI;
				return 1'b0;
			end
			ST_SIZE_HI: begin
				blk_start = tbl_pos - 64'd6;
				blk_size[31:16] = hw;
				tbl_pos += 64'd2;
				if (blk_size == 0) begin
					res = close_run(KIND_ERROR, ERR_ZERO_SIZE);
					return 1'b1;
				end
				if (blk_size > cfg_dir_size) begin
					res = close_run(KIND_ERROR, ERR_OVER_DIRECTORY);
					return 1'b1;
				end
				if (blk_size < 32'd8 || blk_size[0]) begin
					res = close_run(KIND_ERROR, ERR_MALFORMED_SIZE);
					return 1'b1;
				end
				if (blk_start + {32'd0, blk_size} > {32'd0, cfg_image_size}) begin
					res = close_run(KIND_ERROR, ERR_PAST_IMAGE);
					return 1'b1;
				end
				if (page_addr >= cfg_image_size) begin
					res = close_run(KIND_ERROR, ERR_BAD_PAGE);
					return 1'b1;
				end
				bytes_left = blk_size - 32'd8;
				if (bytes_left == 0)
					return close_block(1'b0, res);
				state = ST_ENTRY;
				return 1'b0;
			end
			ST_ENTRY: begin
				etype = hw[15:12];
				have = 1'b1;
				tbl_pos += 64'd2;
				bytes_left = (bytes_left >= 32'd2) ? bytes_left - 32'd2 : 32'd0;
				res.kind = KIND_FIXUP;
				res.offset = {1'b0, page_addr} + {21'd0, hw[11:0]};
				res.index = blk_count;
				res.err = NO_ERROR;
				case (etype)
					ETYPE_ABS: have = 1'b0;
					ETYPE_HIGH: begin
						res.width = FW_16;
						res.addend = {48'd0, cfg_delta[31:16]};
					end
					ETYPE_LOW: begin
						res.width = FW_16;
						res.addend = {48'd0, cfg_delta[15:0]};
					end
					ETYPE_HIGHLOW: begin
						res.width = FW_32;
						res.addend = {32'd0, cfg_delta[31:0]};
					end
					ETYPE_DIR64: begin
						res.width = FW_64;
						res.addend = cfg_delta;
					end
					default: begin
						res = close_run(KIND_ERROR, ERR_UNKNOWN_TYPE);
						return 1'b1;
					end
				endcase
				if (bytes_left == 0)
					return close_block(have, res);
				return have;
			end
			ST_DONE_PENDING: begin
				res = close_run(KIND_DONE, NO_ERROR);
				return 1'b1;
			end
			default: begin
				state = ST_IDLE;
				finished = 1'b1;
				return 1'b0;
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		relo_result_t want;
		relo_result_t got;
		relo_result_t fresh;
		if (!arst_n) begin
			cfg_delta <= '0;
			cfg_image_size <= '0;
			cfg_dir_size <= '0;
			cfg_offset <= '0;
			state <= ST_IDLE;
			page_addr <= '0;
			blk_size <= '0;
			bytes_left <= '0;
			tbl_pos <= '0;
			blk_count <= '0;
			finished <= 1'b1;
			awaited_results.delete();
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_LOAD_DELTA:     cfg_delta = cfg_wdata;
					CFG_IMAGE_SIZE:     cfg_image_size = cfg_wdata[31:0];
					CFG_DIRECTORY_SIZE: cfg_dir_size = cfg_wdata[31:0];
					CFG_TABLE_OFFSET:   cfg_offset = cfg_wdata[31:0];
					default: ;
				endcase
			end
			if (result_mon.valid && result_mon.ready) begin
				got.kind = result_mon.result_kind;
				got.offset = result_mon.fixup_offset;
				got.width = result_mon.fixup_width;
				got.addend = result_mon.addend;
				got.err = result_mon.error_code;
				got.index = result_mon.block_index;
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected result kind=%0d off=%h width=%0d addend=%h err=%0d block=%0d",
						$time, got.kind, got.offset, got.width, got.addend, got.err, got.index);
					mismatches = mismatches + 1;
				end else begin
					want = awaited_results.pop_front();
					if (want !== got) begin
						$display("%0t: result mismatch", $time);
						$display("  expected kind=%0d off=%h width=%0d addend=%h err=%0d block=%0d",
							want.kind, want.offset, want.width, want.addend, want.err, want.index);
						$display("  actual   kind=%0d off=%h width=%0d addend=%h err=%0d block=%0d",
							got.kind, got.offset, got.width, got.addend, got.err, got.index);
						mismatches = mismatches + 1;
					end
				end
			end
			if (item_mon.valid && item_mon.ready) begin
				if (parse_halfword(item_mon.table_start, item_mon.halfword, fresh))
					awaited_results.push_back(fresh);
			end
			outstanding <= awaited_results.size();
		end
	end

endmodule

@@ bench/tb_pe_base_relocation_parser_unit.sv @@
// ----------------------------------------------------------------------------
// tb_pe_base_relocation_parser_unit
// Drives relocation tables into the parser under several configurations and
// idling patterns: directed start checks and a mixed table, then random tables
// with occasional broken headers, bad entry types, truncation and noise.
// The checker judges the results.
// ----------------------------------------------------------------------------
module tb_pe_base_relocation_parser_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import pbrp_pkg::*;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idling_t;

	typedef enum int {
		F_NONE,
		F_SIZE_ZERO,
		F_SIZE_OVER,
		F_SIZE_MALFORMED,
		F_PAGE_OUT,
		F_TYPE_UNKNOWN,
		F_TRUNCATE,
		F_OVERSIZE,
		F_NOISE
	} fault_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DELTA_W-1:0]   cfg_wdata;

	int          send_gap_pct;
	int          recv_stall_pct;
	int          items_sent;
	int          mismatches;
	int          outstanding;
	logic [31:0] cur_img;
	logic [31:0] cur_dir;

	pbrp_in_if  item_ch ();
	pbrp_out_if result_ch ();

	pe_base_relocation_parser_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.item_in    (item_ch),
		.result_out (result_ch)
	);

	relocation_result_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.item_mon    (item_ch),
		.result_mon  (result_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial result_ch.ready = 1'b0;

	always @(posedge clk) begin
		result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	task automatic set_idling(input idling_t m);
		case (m)
			IDLE_NONE: begin
				send_gap_pct = 0;
				recv_stall_pct = 0;
			end
			IDLE_SENDER: begin
				send_gap_pct = 59;
				recv_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_gap_pct = 0;
				recv_stall_pct = 59;
			end
			default: begin
				send_gap_pct = 24;
				recv_stall_pct = 24;
			end
		endcase
	endtask

	task automatic send_item(input logic start, input logic [15:0] hw);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.table_start <= start;
		item_ch.halfword <= hw;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic wait_drained();
		int guard;
		guard = 0;
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (6) @(posedge clk);
	endtask

	task automatic load_config(input logic [63:0] delta, input logic [31:0] img,
			input logic [31:0] dir, input logic [31:0] off);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= CFG_LOAD_DELTA;
		cfg_wdata <= delta;
		@(posedge clk);
		cfg_index <= CFG_IMAGE_SIZE;
		cfg_wdata <= {32'd0, img};
		@(posedge clk);
		cfg_index <= CFG_DIRECTORY_SIZE;
		cfg_wdata <= {32'd0, dir};
		@(posedge clk);
		cfg_index <= CFG_TABLE_OFFSET;
		cfg_wdata <= {32'd0, off};
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_img = img;
		cur_dir = dir;
	endtask

	task automatic send_table();
		fault_t      fault;
		int unsigned fault_blk;
		int unsigned fault_ent;
		int unsigned nent;
		int unsigned span;
		int unsigned blk;
		logic [31:0] rem;
		logic [31:0] bsize;
		logic [31:0] hdr_size;
		logic [31:0] page;
		logic [3:0]  et;
		logic        lead;
		logic        cut;
		fault = F_NONE;
		if ($urandom_range(0, 99) >= 70)
			fault = fault_t'($urandom_range(F_SIZE_ZERO, F_NOISE));
		if (fault == F_NOISE) begin
			repeat ($urandom_range(1, 8))
				send_item($urandom_range(0, 9) == 0, 16'($urandom));
			return;
		end
		fault_blk = (fault == F_OVERSIZE) ? 1 : $urandom_range(0, 2);
		if (cur_dir > 32'd256)
			rem = 32'd8 * $urandom_range(1, 4) + 32'd2 * $urandom_range(0, 12);
		else
			rem = cur_dir;
		lead = 1'b1;
		blk = 0;
		while (rem != 0) begin
			if (rem < 32'd16) begin
				bsize = rem;
			end else begin
				span = (rem - 8) / 2;
				if (span > 12)
					span = 12;
				bsize = 32'd8 + 32'd2 * $urandom_range(0, span);
				if (rem - bsize < 32'd8)
					bsize = rem;
			end
			page = $urandom_range(0, cur_img - 1);
			hdr_size = bsize;
			cut = 1'b0;
			if (blk == fault_blk) begin
				cut = 1'b1;
				case (fault)
					F_SIZE_ZERO: hdr_size = '0;
					F_SIZE_OVER: hdr_size = cur_dir + 32'd1 + $urandom_range(0, 255);
					F_SIZE_MALFORMED:
						hdr_size = $urandom_range(0, 1) ? $urandom_range(1, 7) : bsize - 32'd1;
					F_PAGE_OUT: page = $urandom_range(cur_img, 32'hFFFF_FFFF);
					F_OVERSIZE: hdr_size = cur_dir;
					default: cut = 1'b0;
				endcase
			end
			send_item(lead, page[15:0]);
			lead = 1'b0;
			send_item(1'b0, page[31:16]);
			send_item(1'b0, hdr_size[15:0]);
			send_item(1'b0, hdr_size[31:16]);
			if (cut)
				return;
			nent = (bsize - 8) / 2;
			fault_ent = $urandom_range(0, nent);
			for (int i = 0; i < nent; i++) begin
				if (blk == fault_blk && i == fault_ent && fault == F_TRUNCATE)
					return;
				if (blk == fault_blk && i == fault_ent && fault == F_TYPE_UNKNOWN) begin
					et = 4'($urandom_range(4, 14));
					if (et >= 4'd10)
						et = et + 4'd1;
					send_item(1'b0, {et, 12'($urandom)});
					return;
				end
				case ($urandom_range(0, 4))
					0: et = ETYPE_ABS;
					1: et = ETYPE_HIGH;
					2: et = ETYPE_LOW;
					3: et = ETYPE_HIGHLOW;
					default: et = ETYPE_DIR64;
				endcase
				send_item(1'b0, {et, 12'($urandom)});
			end
			rem -= bsize;
			blk++;
		end
		if ($urandom_range(0, 1))
			send_item(1'b0, 16'($urandom));
	endtask

	initial begin : stimulus
		logic [63:0] delta;
		logic [31:0] dir;
		logic [31:0] off;
		logic [31:0] img;
		int          mark;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_LOAD_DELTA;
		cfg_wdata = '0;
		item_ch.valid = 1'b0;
		item_ch.table_start = 1'b0;
		item_ch.halfword = '0;
		items_sent = 0;
		cur_img = '0;
		cur_dir = '0;
		set_idling(IDLE_NONE);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		load_config(64'd0, 32'd0, 32'd0, 32'd0);
		send_item(1'b1, 16'h0000);
		load_config('1, 32'h100, 32'd16, 32'hFFFF_FFFF);
		send_item(1'b1, 16'hFFFF);
		load_config('1, 32'h100, 32'd16, 32'hF8);
		send_item(1'b1, 16'h1234);
		load_config(64'd0, 32'hFFFF_FFFF, 32'd16, 32'd0);
		send_item(1'b1, 16'h8000);
		load_config(64'h0123_4567_89AB_CDEF, 32'hFFFF_FFFF, 32'd1, 32'd0);
		send_item(1'b1, 16'h0001);

		load_config(64'hFEDC_BA98_7654_3210, 32'h2000, 32'd32, 32'h1FE0);
		send_item(1'b1, 16'h1000);
		send_item(1'b0, 16'h0000);
		send_item(1'b0, 16'd20);
		send_item(1'b0, 16'h0000);
		send_item(1'b0, 16'h0123);
		send_item(1'b0, 16'h1FFF);
		send_item(1'b0, 16'h2000);
		send_item(1'b0, 16'h3ABC);
		send_item(1'b0, 16'hA555);
		send_item(1'b0, 16'h0FFF);
		send_item(1'b0, 16'h1FFF);
		send_item(1'b0, 16'h0000);
		send_item(1'b0, 16'd12);
		send_item(1'b0, 16'h0000);
		send_item(1'b0, 16'h3001);
		send_item(1'b0, 16'hAFFF);
		send_item(1'b0, 16'hFFFF);
		send_item(1'b1, 16'hFFFF);
		send_item(1'b0, 16'hFFFF);
		send_item(1'b0, 16'h0008);
		send_item(1'b0, 16'h0000);

		for (int p = 0; p < 8; p++) begin
			set_idling(idling_t'(p % 4));
			dir = (p == 5) ? 32'hFFFF_FFFF : 32'd2 * $urandom_range(8, 40);
			if (p == 5) begin
				off = '0;
				img = '1;
			end else if (p == 6) begin
				img = '1;
				off = img - dir;
			end else begin
				off = $urandom_range(0, 32'hFFFF_0000);
				img = $urandom_range(0, 1) ? off + dir : $urandom_range(off + dir, 32'hFFFF_FFFF);
			end
			delta = (p == 7) ? '1 : {$urandom, $urandom};
			load_config(delta, img, dir, off);
			mark = items_sent;
			while (items_sent < mark + 70)
				send_table();
		end

		set_idling(IDLE_NONE);
		wait_drained();
		if (mismatches == 0 && outstanding == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

@@ pe_base_relocation_parser_unit.f @@
+incdir+rtl
rtl/pbrp_pkg.sv
rtl/pbrp_if.sv
rtl/pbrp_cfg.sv
rtl/pbrp_core.sv
rtl/pe_base_relocation_parser_unit.sv
bench/relocation_result_checker.sv
bench/tb_pe_base_relocation_parser_unit.sv
